FILE: rtl/core/fifo_queue_with_id_search_defines.svh
// Assertion helpers for the checker file of the queue block.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef FIFO_QUEUE_WITH_ID_SEARCH_DEFINES_SVH
`define FIFO_QUEUE_WITH_ID_SEARCH_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define FQS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define FQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fqs_pkg.sv
`default_nettype none

package fqs_pkg;

    // Queue geometry
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int COUNT_W = 5;

    // Command codes
    localparam logic [2:0] CMD_PUSH  = 3'd0;
    localparam logic [2:0] CMD_POP   = 3'd1;
    localparam logic [2:0] CMD_PEEK  = 3'd2;
    localparam logic [2:0] CMD_FIND  = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Values returned when no entry is returned
    localparam logic [7:0]         NO_CHAR = 8'd0;
    localparam logic signed [31:0] NO_ID   = -32'sd1;

    typedef struct packed {
        logic [2:0]         command;
        logic [7:0]         item_char;
        logic signed [31:0] item_id;
        logic signed [31:0] search_id;
    } cmd_beat_t;

    typedef struct packed {
        logic [7:0]         out_char;
        logic signed [31:0] out_id;
        logic [1:0]         status;
        logic               is_empty;
        logic [COUNT_W-1:0] entry_count;
    } rsp_beat_t;

    typedef struct packed {
        logic [7:0]         ch;
        logic signed [31:0] id;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [IDX_W-1:0] addr;
        entry_t           wdata;
    } mem_req_t;

    typedef struct packed {
        logic      valid;
        rsp_beat_t beat;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/fqs_ram.sv
`default_nettype none

module fqs_ram #(
    parameter int DEPTH_P = 16,
    parameter int ADDR_W  = 4,
    parameter int DATA_W  = 40
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH_P];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/fqs_ctrl.sv
`default_nettype none

module fqs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  fqs_pkg::cmd_beat_t  cmd,
    output fqs_pkg::mem_req_t   mem_req,
    input  fqs_pkg::entry_t     mem_rdata,
    output fqs_pkg::res_t       res,
    input  logic                res_take
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [fqs_pkg::IDX_W-1:0]     head_reg, head_next;
    logic [fqs_pkg::IDX_W-1:0]     tail_reg, tail_next;
    logic [fqs_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [fqs_pkg::IDX_W-1:0]     scan_pos_reg, scan_pos_next;
    logic [fqs_pkg::CNT_W-1:0]     scan_left_reg, scan_left_next;
    logic [2:0]                    op_reg, op_next;
    logic signed [31:0]            key_reg, key_next;
    logic [7:0]                    res_char_reg, res_char_next;
    logic signed [31:0]            res_id_reg, res_id_next;
    logic [1:0]                    res_status_reg, res_status_next;

    function automatic logic [fqs_pkg::IDX_W-1:0] ring_next(
        input logic [fqs_pkg::IDX_W-1:0] pos
    );
        if (pos == fqs_pkg::IDX_W'(fqs_pkg::DEPTH - 1))
        begin
            return '0;
        end
        return pos + fqs_pkg::IDX_W'(1);
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        scan_pos_next   = scan_pos_reg;
        scan_left_next  = scan_left_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        res_char_next   = res_char_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;

        cmd_stall       = 1'b1;
        mem_req         = '0;
        mem_req.addr    = head_reg;

        res.valid            = 1'b0;
        res.beat.out_char    = res_char_reg;
        res.beat.out_id      = res_id_reg;
        res.beat.status      = res_status_reg;
        res.beat.is_empty    = (count_reg == '0);
        res.beat.entry_count = fqs_pkg::COUNT_W'(count_reg);

        case (state_reg)
            S_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    op_next         = cmd.command;
                    key_next        = cmd.search_id;
                    res_char_next   = fqs_pkg::NO_CHAR;
                    res_id_next     = fqs_pkg::NO_ID;
                    res_status_next = fqs_pkg::ST_OK;
                    state_next      = S_DONE;
                    case (cmd.command)
                        fqs_pkg::CMD_PUSH:
                        begin
                            if (count_reg == fqs_pkg::CNT_W'(fqs_pkg::DEPTH))
                            begin
                                res_status_next = fqs_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_req.we       = 1'b1;
                                mem_req.addr     = tail_reg;
                                mem_req.wdata.ch = cmd.item_char;
                                mem_req.wdata.id = cmd.item_id;
                                tail_next        = ring_next(tail_reg);
                                count_next       = count_reg + fqs_pkg::CNT_W'(1);
                            end
                        end
                        fqs_pkg::CMD_POP,
                        fqs_pkg::CMD_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = fqs_pkg::ST_MISS;
                            end
                            else
                            begin
                                mem_req.re = 1'b1;
                                state_next = S_RD;
                            end
                        end
                        fqs_pkg::CMD_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = fqs_pkg::ST_MISS;
                            end
                            else
                            begin
                                mem_req.re     = 1'b1;
                                scan_pos_next  = ring_next(head_reg);
                                scan_left_next = count_reg;
                                state_next     = S_SCAN;
                            end
                        end
                        fqs_pkg::CMD_CLEAR:
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            // unused codes: report ok, leave state alone
                        end
                    endcase
                end
            end
            S_RD:
            begin
                res_char_next = mem_rdata.ch;
                res_id_next   = mem_rdata.id;
                if (op_reg == fqs_pkg::CMD_POP)
                begin
                    head_next  = ring_next(head_reg);
                    count_next = count_reg - fqs_pkg::CNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                // compare the entry read last cycle, fetch the next one meanwhile
                if (mem_rdata.id == key_reg)
                begin
                    res_char_next = mem_rdata.ch;
                    res_id_next   = mem_rdata.id;
                    state_next    = S_DONE;
                end
                else if (scan_left_reg == fqs_pkg::CNT_W'(1))
                begin
                    res_status_next = fqs_pkg::ST_MISS;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_req.re     = 1'b1;
                    mem_req.addr   = scan_pos_reg;
                    scan_pos_next  = ring_next(scan_pos_reg);
                    scan_left_next = scan_left_reg - fqs_pkg::CNT_W'(1);
                end
            end
            S_DONE:
            begin
                res.valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_pos_reg   <= scan_pos_next;
        scan_left_reg  <= scan_left_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        res_char_reg   <= res_char_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/fifo_queue_with_id_search.sv
// Channel   Direction  Beat type            Handshake
// cmd       in         fqs_pkg::cmd_beat_t  cmd_valid / cmd_stall
// rsp       out        fqs_pkg::rsp_beat_t  rsp_valid / rsp_stall
//
// One command in flight; push, clear and unused codes finish without a memory read,
// pop and peek make one entry memory read, and find reads one entry per cycle from
// the head and stops at the first matching id.
// A result reaches the output register before the next accept.
// A stalled rsp beat holds there; a finished result waits and holds off new commands.
// Reset clears head, tail and count; the entry memory needs no clearing pass.
`default_nettype none

module fifo_queue_with_id_search (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  fqs_pkg::cmd_beat_t cmd,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output fqs_pkg::rsp_beat_t rsp
);

    fqs_pkg::mem_req_t  mem_req;
    fqs_pkg::entry_t    mem_rdata;
    fqs_pkg::res_t      res;
    logic               res_take;

    logic               out_valid_reg, out_valid_next;
    fqs_pkg::rsp_beat_t out_data_reg;

    // Sequencer: pointers, count and the per-command walk over the memory
    fqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res       (res),
        .res_take  (res_take)
    );

    // Entry store: character and id side by side in one word
    fqs_ram #(
        .DEPTH_P (fqs_pkg::DEPTH),
        .ADDR_W  (fqs_pkg::IDX_W),
        .DATA_W  ($bits(fqs_pkg::entry_t))
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    // Load a finished result when the output slot is empty or draining
    assign res_take       = res.valid && (!out_valid_reg || !rsp_stall);
    assign out_valid_next = res_take || (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the payload while stalled; advance only on a new result
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res.beat;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/fqs_checker.sv
`default_nettype none
`include "fifo_queue_with_id_search_defines.svh"

module fqs_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               cmd_stall,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  fqs_pkg::rsp_beat_t rsp
);

    // one command at a time: an accepted beat closes the input side
    `FQS_ASSERT_NEXT(a_single_inflight, cmd_valid && !cmd_stall, cmd_stall, "second command accepted while busy")

    `FQS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled rsp beat changed")

    `FQS_ASSERT_IMPL(a_empty_flag, rsp_valid, rsp.is_empty == (rsp.entry_count == '0), "is_empty disagrees with entry_count")

    `FQS_ASSERT_IMPL(a_no_entry, rsp_valid && rsp.status != fqs_pkg::ST_OK, rsp.out_char == fqs_pkg::NO_CHAR && rsp.out_id == fqs_pkg::NO_ID, "miss or full beat carries entry data")

endmodule

bind fifo_queue_with_id_search fqs_checker u_fqs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Unused command codes: the block must ignore them.
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam logic signed [31:0] ID_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ID_MAX = 32'sh7fff_ffff;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 300;                // long receiver hold-off
    localparam int TAIL_CYCLES  = fqs_pkg::DEPTH + 8; // longest find plus margin
    localparam int PRINT_CAP    = 40;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports
    // ------------------------------------------------------------------
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               rsp_stall = 1'b0;
    fqs_pkg::cmd_beat_t cmd_beat  = '0;
    logic               cmd_stall;
    logic               rsp_valid;
    fqs_pkg::rsp_beat_t rsp_beat;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    fifo_queue_with_id_search uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd_beat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_beat)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the queue and the results it predicts
    // ------------------------------------------------------------------
    fqs_pkg::entry_t           shadow_mem [fqs_pkg::DEPTH];
    logic [fqs_pkg::IDX_W-1:0] shadow_head  = '0;
    logic [fqs_pkg::IDX_W-1:0] shadow_tail  = '0;
    int                        shadow_count = 0;

    fqs_pkg::rsp_beat_t rsp_due [$];

    int error_count   = 0;
    int beats_sent    = 0;
    int rsp_checked   = 0;
    int find_hits     = 0;
    int pushes_dropped = 0;
    int cycle_count   = 0;

    // Idle mix, in cycles per hundred, changed between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // The stimulus bumps this to ask the receiver for one long hold-off.
    int hold_trigger = 0;

    function automatic logic [fqs_pkg::IDX_W-1:0] ring_advance(
        input logic [fqs_pkg::IDX_W-1:0] pos
    );
        if (int'(pos) == fqs_pkg::DEPTH - 1)
            return '0;
        return pos + fqs_pkg::IDX_W'(1);
    endfunction

    // Apply one command to the shadow queue and return the result it must give.
    function automatic fqs_pkg::rsp_beat_t apply_command(input fqs_pkg::cmd_beat_t c);
        fqs_pkg::rsp_beat_t        r;
        logic [fqs_pkg::IDX_W-1:0] pos;
        bit                        hit;
        int                        k;
        r.out_char = fqs_pkg::NO_CHAR;
        r.out_id   = fqs_pkg::NO_ID;
        r.status   = fqs_pkg::ST_OK;
        case (c.command)
            fqs_pkg::CMD_PUSH:
            begin
                if (shadow_count >= fqs_pkg::DEPTH)
                begin
                    r.status = fqs_pkg::ST_FULL;
                    pushes_dropped++;
                end
                else
                begin
                    shadow_mem[shadow_tail].ch = c.item_char;
                    shadow_mem[shadow_tail].id = c.item_id;
                    shadow_tail  = ring_advance(shadow_tail);
                    shadow_count = shadow_count + 1;
                end
            end
            fqs_pkg::CMD_POP, fqs_pkg::CMD_PEEK:
            begin
                if (shadow_count == 0)
                    r.status = fqs_pkg::ST_MISS;
                else
                begin
                    r.out_char = shadow_mem[shadow_head].ch;
                    r.out_id   = shadow_mem[shadow_head].id;
                    if (c.command == fqs_pkg::CMD_POP)
                    begin
                        shadow_head  = ring_advance(shadow_head);
                        shadow_count = shadow_count - 1;
                    end
                end
            end
            fqs_pkg::CMD_FIND:
            begin
                // Scan from the head; the first matching id wins.
                pos = shadow_head;
                hit = 1'b0;
                for (k = 0; k < shadow_count && !hit; k++)
                begin
                    if (shadow_mem[pos].id == c.search_id)
                    begin
                        r.out_char = shadow_mem[pos].ch;
                        r.out_id   = shadow_mem[pos].id;
                        hit        = 1'b1;
                    end
                    pos = ring_advance(pos);
                end
                if (hit)
                    find_hits++;
                else
                    r.status = fqs_pkg::ST_MISS;
            end
            fqs_pkg::CMD_CLEAR:
            begin
                shadow_head  = '0;
                shadow_tail  = '0;
                shadow_count = 0;
            end
            default:
            begin
                // spare codes leave everything alone
            end
        endcase
        r.is_empty    = (shadow_count == 0);
        r.entry_count = shadow_count[fqs_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one command beat, hold it until it is taken
    // ------------------------------------------------------------------
    task automatic offer_command(input fqs_pkg::cmd_beat_t c);
        // Idle a random number of cycles first; the gap never looks at stall.
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_beat  <= c;
        // Hold valid and payload until an edge sees stall low.
        do
            @(posedge clk);
        while (cmd_stall);
        rsp_due.push_back(apply_command(c));
        beats_sent++;
    endtask

    function automatic fqs_pkg::cmd_beat_t make_cmd(input logic [2:0] code,
                                                    input logic [7:0] ch,
                                                    input logic signed [31:0] id,
                                                    input logic signed [31:0] key);
        fqs_pkg::cmd_beat_t c;
        c.command   = code;
        c.item_char = ch;
        c.item_id   = id;
        c.search_id = key;
        return c;
    endfunction

    // Ids mostly from a tight pool around zero so finds hit duplicates;
    // -1 is in the pool since it looks just like the "no entry" id.
    function automatic logic signed [31:0] pick_id();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return int'($urandom_range(6)) - 3;
        if (sel == 6)
            return ID_MIN;
        if (sel == 7)
            return ID_MAX;
        return $urandom;
    endfunction

    // Search key: usually an id that is held right now, else anything.
    function automatic logic signed [31:0] pick_key();
        logic [fqs_pkg::IDX_W-1:0] slot;
        if (shadow_count > 0 && $urandom_range(9) < 6)
        begin
            slot = fqs_pkg::IDX_W'((int'(shadow_head)
                                    + int'($urandom_range(shadow_count - 1)))
                                   % fqs_pkg::DEPTH);
            return shadow_mem[slot].id;
        end
        return pick_id();
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall, or one long hold-off on request
    // ------------------------------------------------------------------
    int hold_left = 0;
    int hold_seen = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Checker: compare every accepted result beat with the oldest one due
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("mismatch at result %0d, %s: got %h, want %h",
                     rsp_checked, what, got, want);
    endtask

    always @(posedge clk)
    begin
        fqs_pkg::rsp_beat_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_due.size() == 0)
                report_mismatch("result with none due, out_id", rsp_beat.out_id,
                                fqs_pkg::NO_ID);
            else
            begin
                want = rsp_due.pop_front();
                if (rsp_beat.out_char !== want.out_char)
                    report_mismatch("out_char", 32'(rsp_beat.out_char),
                                    32'(want.out_char));
                if (rsp_beat.out_id !== want.out_id)
                    report_mismatch("out_id", rsp_beat.out_id, want.out_id);
                if (rsp_beat.status !== want.status)
                    report_mismatch("status", 32'(rsp_beat.status), 32'(want.status));
                if (rsp_beat.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(rsp_beat.is_empty),
                                    32'(want.is_empty));
                if (rsp_beat.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(rsp_beat.entry_count),
                                    32'(want.entry_count));
            end
            rsp_checked++;
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, rsp_due.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Empty queue, spare codes, field extremes, id -1 held as a real entry.
    task automatic test_directed();
        offer_command(make_cmd(fqs_pkg::CMD_POP,   8'h00, 0, 0));
        offer_command(make_cmd(fqs_pkg::CMD_PEEK,  8'h00, 0, 0));
        offer_command(make_cmd(fqs_pkg::CMD_FIND,  8'h00, 0, fqs_pkg::NO_ID));
        offer_command(make_cmd(CMD_SPARE_5, 8'hff, ID_MAX, ID_MIN));
        offer_command(make_cmd(CMD_SPARE_6, 8'h00, ID_MIN, ID_MAX));
        offer_command(make_cmd(CMD_SPARE_7, 8'hff, fqs_pkg::NO_ID, fqs_pkg::NO_ID));
        offer_command(make_cmd(fqs_pkg::CMD_PUSH,  8'h00, ID_MIN, ID_MAX));
        offer_command(make_cmd(fqs_pkg::CMD_PUSH,  8'hff, ID_MAX, ID_MIN));
        offer_command(make_cmd(fqs_pkg::CMD_PUSH,  8'h41, fqs_pkg::NO_ID, 0));
        offer_command(make_cmd(fqs_pkg::CMD_PEEK,  8'h00, 0, 0));
        offer_command(make_cmd(fqs_pkg::CMD_FIND,  8'h00, 0, ID_MAX));
        offer_command(make_cmd(fqs_pkg::CMD_FIND,  8'h00, 0, fqs_pkg::NO_ID));
        offer_command(make_cmd(fqs_pkg::CMD_FIND,  8'h00, 0, 32'sd12345));
        offer_command(make_cmd(fqs_pkg::CMD_POP,   8'h00, 0, 0));
        offer_command(make_cmd(fqs_pkg::CMD_FIND,  8'h00, 0, ID_MIN));
        offer_command(make_cmd(fqs_pkg::CMD_CLEAR, 8'hff, ID_MAX, ID_MAX));
        offer_command(make_cmd(fqs_pkg::CMD_POP,   8'h00, 0, 0));
        offer_command(make_cmd(fqs_pkg::CMD_FIND,  8'h00, 0, ID_MAX));
    endtask

    // Fill to the brim, push once more, scan the whole depth, then wrap.
    task automatic test_full_and_wrap();
        int k;
        for (k = 0; k < fqs_pkg::DEPTH; k++)
            offer_command(make_cmd(fqs_pkg::CMD_PUSH, 8'(8'h30 + k), k % 5, 0));
        offer_command(make_cmd(fqs_pkg::CMD_PUSH, 8'hee, 32'sd999, 0));
        offer_command(make_cmd(fqs_pkg::CMD_FIND, 8'h00, 0, (fqs_pkg::DEPTH - 1) % 5));
        offer_command(make_cmd(fqs_pkg::CMD_FIND, 8'h00, 0, 32'sd999));
        for (k = 0; k < 3; k++)
            offer_command(make_cmd(fqs_pkg::CMD_POP, 8'h00, 0, 0));
        for (k = 0; k < 3; k++)
            offer_command(make_cmd(fqs_pkg::CMD_PUSH, 8'(8'h60 + k), 32'sd100 + k, 0));
        offer_command(make_cmd(fqs_pkg::CMD_FIND, 8'h00, 0, 32'sd102));
        offer_command(make_cmd(fqs_pkg::CMD_PEEK, 8'h00, 0, 0));
        offer_command(make_cmd(fqs_pkg::CMD_CLEAR, 8'h00, 0, 0));
    endtask

    // Mostly well-formed traffic with random content, plus fill and drain
    // runs to reach the full and empty corners, clears and spare codes.
    task automatic test_random(input int beats);
        int done;
        int pick;
        done = 0;
        while (done < beats)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                while (shadow_count < fqs_pkg::DEPTH)
                begin
                    offer_command(make_cmd(fqs_pkg::CMD_PUSH, 8'($urandom), pick_id(),
                                           $urandom));
                    done++;
                end
                offer_command(make_cmd(fqs_pkg::CMD_PUSH, 8'($urandom), pick_id(),
                                       $urandom));
                done++;
            end
            else if (pick < 7)
            begin
                while (shadow_count > 0)
                begin
                    offer_command(make_cmd(fqs_pkg::CMD_POP, 8'($urandom), $urandom,
                                           $urandom));
                    done++;
                end
                offer_command(make_cmd(fqs_pkg::CMD_POP, 8'($urandom), $urandom,
                                       $urandom));
                done++;
            end
            else if (pick < 9)
            begin
                offer_command(make_cmd(fqs_pkg::CMD_CLEAR, 8'($urandom), $urandom,
                                       $urandom));
                done++;
            end
            else if (pick < 11)
                offer_command(make_cmd(3'(CMD_SPARE_5 + $urandom_range(2)),
                                       8'($urandom), $urandom, $urandom));
            else if (pick < 45)
            begin
                offer_command(make_cmd(fqs_pkg::CMD_PUSH, 8'($urandom), pick_id(),
                                       $urandom));
                done++;
            end
            else if (pick < 63)
            begin
                offer_command(make_cmd(fqs_pkg::CMD_POP, 8'($urandom), $urandom,
                                       $urandom));
                done++;
            end
            else if (pick < 72)
            begin
                offer_command(make_cmd(fqs_pkg::CMD_PEEK, 8'($urandom), $urandom,
                                       $urandom));
                done++;
            end
            else
            begin
                offer_command(make_cmd(fqs_pkg::CMD_FIND, 8'($urandom), $urandom,
                                       pick_key()));
                done++;
            end
        end
    endtask

    // Hold the result channel off for a long stretch while commands keep
    // coming, so the block backs up and stalls its command side.
    task automatic test_backpressure();
        int k;
        set_idle(0, 0);
        hold_trigger <= hold_trigger + 1;
        for (k = 0; k < 12; k++)
            offer_command(make_cmd(fqs_pkg::CMD_PUSH, 8'($urandom), pick_id(), $urandom));
        for (k = 0; k < 8; k++)
            offer_command(make_cmd(fqs_pkg::CMD_FIND, 8'($urandom), $urandom, pick_key()));
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(23, 47);
        test_directed();
        test_full_and_wrap();
        test_random(420);

        set_idle(47, 23);
        test_random(420);

        test_backpressure();

        set_idle(0, 0);
        test_random(420);

        // Drop valid, let every due result come home, then watch a while
        // longer for strays.
        cmd_valid <= 1'b0;
        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d command beats, %0d results checked, %0d find hits, %0d full drops",
                 beats_sent, rsp_checked, find_hits, pushes_dropped);
        $display("idle mixes 23/47, 47/23 and none, plus one %0d-cycle result hold-off",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
